// File: src/drx16_pkg.sv
// ----------------------------------------------------------------------------
// drx16_pkg
// Shared types and constants for the xorshift16 dice roller.
// ----------------------------------------------------------------------------
`default_nettype none

package drx16_pkg;

  localparam int WordW = 16;
  localparam int DivW  = WordW + 1;

  typedef enum logic [2:0] {
    FUNC_RANGE = 3'd0,
    FUNC_D6    = 3'd1,
    FUNC_2D6   = 3'd2,
    FUNC_D3    = 3'd3,
    FUNC_MOD   = 3'd4,
    FUNC_BEST  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_DIV1,
    S_DIV2,
    S_FINISH
  } state_t;

  // 65535 / faces + 1
  localparam logic [DivW-1:0] D6_DIVISOR = DivW'(65535 / 6 + 1);
  localparam logic [DivW-1:0] D3_DIVISOR = DivW'(65535 / 3 + 1);

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/drx16_div.sv
// ----------------------------------------------------------------------------
// drx16_div
// Restoring divider, 16-bit dividend by 17-bit divisor, one quotient bit a
// cycle. done pulses for one cycle once the quotient is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module drx16_div
  import drx16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CntW = $clog2(WordW);

  logic             busy;
  logic             done;
  logic [CntW-1:0]  cnt;
  logic [DivW-1:0]  rem;
  logic [DivW-1:0]  dsr;
  logic [WordW-1:0] quo;

  logic [DivW:0]    shifted;
  logic             fits;
  logic [DivW:0]    diff;

  always_comb begin
    shifted = {rem, quo[WordW-1]};
    fits    = shifted >= {1'b0, dsr};
    diff    = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= fits ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo <= {quo[WordW-2:0], fits};
    end else if (req.start) begin
      rem <= '0;
      dsr <= req.divisor;
      quo <= req.dividend;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (!rst && req.start && busy) $error("divider started while busy");
  end

endmodule

`default_nettype wire

// File: src/dice_roll_xorshift16_unit.sv
// Per function: one die is a draw reduced by threshold compares (constant
// divisors), two dice are two draws, a range draw whose span wraps to zero is
// one pass and any other range draw two passes through one shared bit-serial
// divider, modifier-only and unused codes go to finish; a full output stalls.
// One word in flight: the next is taken the cycle after the result is loaded.
// Reset clears the generator state, seeded flag, seed and output valid.
// ----------------------------------------------------------------------------
// dice_roll_xorshift16_unit
// Xorshift16 generator with range reduction and dice modes.
// ----------------------------------------------------------------------------
`default_nettype none

module dice_roll_xorshift16_unit
  import drx16_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         func,
  input  wire logic signed [15:0] range_low,
  input  wire logic signed [15:0] range_high,
  input  wire logic signed [7:0]  modifier,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             value
);

  function automatic logic [WordW-1:0] xs_step(input logic [WordW-1:0] cur);
    logic [WordW-1:0] s;
    s = (cur == '0) ? '1 : cur;
    s = s ^ (s << 7);
    s = s ^ (s >> 9);
    s = s ^ (s << 8);
    return s;
  endfunction

  // quotient by a die divisor, counted against its multiples
  function automatic logic [2:0] die_quot(input logic [WordW-1:0] x, input logic d3);
    logic [DivW-1:0] bound;
    logic [2:0]      q;
    q = '0;
    for (int k = 1; k <= 5; k++) begin
      bound = d3 ? DivW'(k * D3_DIVISOR) : DivW'(k * D6_DIVISOR);
      if ({1'b0, x} >= bound) q = q + 3'd1;
    end
    return q;
  endfunction

  state_t           state, state_next;
  func_t            func_r, func_next;
  logic [WordW-1:0] lo_r, lo_next;
  logic [WordW-1:0] hi_r, hi_next;
  logic [7:0]       mod_r, mod_next;
  logic             second, second_next;
  logic [WordW-1:0] x_r, x_next;
  logic [7:0]       acc, acc_next;
  logic [WordW-1:0] result, result_next;
  logic [WordW-1:0] prng, prng_next;
  logic             seeded, seeded_next;
  logic [WordW-1:0] seed;
  logic             out_valid_next;
  logic [WordW-1:0] value_next;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [WordW-1:0] cur;
  logic [WordW-1:0] x_new;
  logic [WordW-1:0] span;
  logic [WordW-1:0] lo_eff;
  logic [WordW-1:0] quot;
  logic [WordW-1:0] draw;
  logic [7:0]       mod_eff;
  logic [7:0]       die;
  logic             can_load;

  drx16_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next     = state;
    func_next      = func_r;
    lo_next        = lo_r;
    hi_next        = hi_r;
    mod_next       = mod_r;
    second_next    = second;
    x_next         = x_r;
    acc_next       = acc;
    result_next    = result;
    prng_next      = prng;
    seeded_next    = seeded;
    out_valid_next = out_valid;
    value_next     = value;
    div_req        = '0;
    in_ready       = (state == S_IDLE);

    cur      = seeded ? prng : seed;
    x_new    = xs_step(cur);
    span     = hi_r - lo_r + 1'b1;
    lo_eff   = (func_r == FUNC_RANGE) ? lo_r : WordW'(1);
    quot     = (func_r == FUNC_RANGE) ? div_rsp.quotient
                                      : WordW'(die_quot(x_r, func_r == FUNC_D3));
    draw     = lo_eff + quot;
    mod_eff  = (func_r == FUNC_2D6 && !second) ? 8'd0 : mod_r;
    die      = draw[7:0] + mod_eff;
    can_load = !out_valid || out_ready;

    if (out_valid && out_ready) out_valid_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          func_next   = func_t'(func);
          lo_next     = range_low;
          hi_next     = range_high;
          mod_next    = modifier;
          second_next = 1'b0;
          unique case (func)
            FUNC_RANGE, FUNC_D6, FUNC_2D6, FUNC_D3, FUNC_BEST: begin
              state_next = S_DRAW;
            end
            FUNC_MOD: begin
              result_next = {8'd0, modifier};
              state_next  = S_FINISH;
            end
            default: begin
              result_next = '0;
              state_next  = S_FINISH;
            end
          endcase
        end
      end
      S_DRAW: begin
        prng_next   = x_new;
        seeded_next = 1'b1;
        x_next      = x_new;
        state_next  = S_DIV2;
        if (func_r == FUNC_RANGE) begin
          div_req.start    = 1'b1;
          div_req.dividend = x_new;
          if (span == '0) begin
            div_req.divisor = DivW'(1);
          end else begin
            div_req.dividend = '1;
            div_req.divisor  = {1'b0, span};
            state_next       = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = x_r;
          div_req.divisor  = {1'b0, div_rsp.quotient} + 1'b1;
          state_next       = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done || func_r != FUNC_RANGE) begin
          state_next = S_FINISH;
          if (func_r == FUNC_RANGE) begin
            result_next = draw;
          end else if (!second) begin
            acc_next    = die;
            result_next = {8'd0, die};
            if (func_r == FUNC_2D6 || func_r == FUNC_BEST) begin
              second_next = 1'b1;
              state_next  = S_DRAW;
            end
          end else if (func_r == FUNC_2D6) begin
            result_next = {8'd0, 8'(acc + die)};
          end else begin
            result_next = {8'd0, (acc > die) ? acc : die};
          end
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          value_next     = result;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prng      <= '0;
      seeded    <= 1'b0;
      seed      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      prng      <= prng_next;
      seeded    <= seeded_next;
      out_valid <= out_valid_next;
      if (cfg_we) seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_next;
    lo_r   <= lo_next;
    hi_r   <= hi_next;
    mod_r  <= mod_next;
    second <= second_next;
    x_r    <= x_next;
    acc    <= acc_next;
    result <= result_next;
    value  <= value_next;
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while one is in flight");

  a_seeded_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag dropped");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && state != S_FINISH |=> !out_valid)
    else $error("output word repeated");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV1 || state == S_DIV2)
    else $error("quotient arrived outside a division state");

  a_load_in_finish: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(state) == S_FINISH)
    else $error("output loaded outside finish");

endmodule

`default_nettype wire
